/* design/lzbd_pkg.sv */
// Shared constants and transfer types for the LZ bitstream decompressor.
package lzbd_pkg;

  localparam int unsigned HIST_DEPTH = 65536;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned CNT_W      = 24;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned RES_CW     = 7;
  localparam logic [RES_CW-1:0] MAX_RES = 7'd64;
  localparam logic [2:0] CAP_MAX = 3'd4;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_LIT  = 2'd1,
    CMD_COPY = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        lit;
    logic [LEN_W-1:0]  len;
    logic [DIST_W-1:0] span;
  } cmd_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             present;
    logic             done;
    logic [CNT_W-1:0] total;
  } rec_t;

endpackage

/* design/lzbd_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
module lzbd_ram #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/lzbd_parse.sv */
// Bit-serial token decoder: flag, literal, unary length prefix, length and offset fields.
module lzbd_parse import lzbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       clr_i,
  input  logic       bit_i,
  input  logic       at_limit_i,
  input  logic [3:0] lob_i,
  input  logic [2:0] cap_i,
  output cmd_t       cmd_o,
  output logic       idle_o
);

  localparam logic [2:0] PH_FLAG = 3'd0;
  localparam logic [2:0] PH_LIT  = 3'd1;
  localparam logic [2:0] PH_PRE  = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_OFF  = 3'd4;

  logic [2:0]        phase_q, phase_d;
  logic [2:0]        pre_q, pre_d;
  logic [15:0]       acc_q, acc_d;
  logic [4:0]        left_q, left_d;
  logic [LEN_W-1:0]  plen_q, plen_d;

  logic [2:0]  cap_sat;
  logic [2:0]  pre_inc;
  logic [15:0] acc_sh;
  logic [15:0] len_calc;
  logic [LEN_W-1:0] len_long;

  assign cap_sat  = (cap_i > CAP_MAX) ? CAP_MAX : cap_i;
  assign pre_inc  = pre_q + 3'd1;
  assign acc_sh   = {acc_q[14:0], bit_i};
  assign len_calc = (acc_sh | (16'd1 << pre_q)) + 16'd1;
  assign len_long = len_calc[LEN_W-1:0];
  assign idle_o   = (phase_q == PH_FLAG);

  always_comb begin
    phase_d    = phase_q;
    pre_d      = pre_q;
    acc_d      = acc_q;
    left_d     = left_q;
    plen_d     = plen_q;
    cmd_o.kind = CMD_NONE;
    cmd_o.lit  = acc_sh[7:0];
    cmd_o.len  = plen_q;
    cmd_o.span = acc_sh + DIST_W'(plen_q);
    unique case (phase_q)
      PH_FLAG: begin
        if (!at_limit_i) begin
          acc_d = '0;
          pre_d = '0;
          if (!bit_i) begin
            left_d  = 5'd8;
            phase_d = PH_LIT;
          end else if (cap_sat == 3'd0) begin
            plen_d  = LEN_W'(2);
            left_d  = 5'd8;
            phase_d = PH_OFF;
          end else begin
            phase_d = PH_PRE;
          end
        end
      end
      PH_LIT: begin
        acc_d  = acc_sh;
        left_d = left_q - 5'd1;
        if (left_q == 5'd1) begin
          phase_d = PH_FLAG;
          if (!at_limit_i) begin
            cmd_o.kind = CMD_LIT;
          end
        end
      end
      PH_PRE: begin
        if (bit_i) begin
          pre_d = pre_inc;
          if (pre_inc >= cap_sat) begin
            acc_d   = '0;
            left_d  = {2'b00, pre_inc};
            phase_d = PH_LEN;
          end
        end else if (pre_q == 3'd0) begin
          acc_d   = '0;
          plen_d  = LEN_W'(2);
          left_d  = 5'd8;
          phase_d = PH_OFF;
        end else begin
          acc_d   = '0;
          left_d  = {2'b00, pre_q};
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        acc_d  = acc_sh;
        left_d = left_q - 5'd1;
        if (left_q == 5'd1) begin
          plen_d = len_long;
          acc_d  = '0;
          left_d = {1'b0, lob_i};
          if (lob_i == 4'd0) begin
            cmd_o.kind = CMD_COPY;
            cmd_o.len  = len_long;
            cmd_o.span = DIST_W'(len_long);
            phase_d    = PH_FLAG;
          end else begin
            phase_d = PH_OFF;
          end
        end
      end
      PH_OFF: begin
        acc_d = acc_sh;
        if (left_q != 5'd0) begin
          left_d = left_q - 5'd1;
        end
        if (left_q <= 5'd1) begin
          cmd_o.kind = CMD_COPY;
          phase_d    = PH_FLAG;
        end
      end
      default: begin
        phase_d = PH_FLAG;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FLAG;
      pre_q   <= '0;
      acc_q   <= '0;
      left_q  <= '0;
      plen_q  <= '0;
    end else if (clr_i) begin
      phase_q <= PH_FLAG;
      pre_q   <= '0;
      acc_q   <= '0;
      left_q  <= '0;
      plen_q  <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      pre_q   <= pre_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      plen_q  <= plen_d;
    end
  end

endmodule

/* design/lzbd_emit.sv */
// Result staging: one held result plus the output register, so the last result of a
// transaction can be tagged when the input transaction ends.
module lzbd_emit import lzbd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t rec_i,
  input  logic flush_i,
  output logic ready_o,
  output logic hold_valid_o,
  input  logic out_stall_i,
  output logic out_valid_o,
  output rec_t out_rec_o,
  output logic out_last_o
);

  rec_t              hold_q;
  logic              hold_vld_q;
  rec_t              out_q;
  logic              out_vld_q;
  logic              out_last_q;
  logic [RES_CW-1:0] cnt_q;

  logic out_free;
  logic keep;
  logic move;

  assign out_free = !out_vld_q || !out_stall_i;
  assign ready_o  = !hold_vld_q || out_free;
  assign keep     = push_i && (cnt_q < MAX_RES);
  assign move     = ready_o && hold_vld_q && (keep || flush_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      hold_vld_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (flush_i && ready_o) begin
        hold_vld_q <= 1'b0;
        cnt_q      <= '0;
      end else if (keep && ready_o) begin
        hold_vld_q <= 1'b1;
        cnt_q      <= cnt_q + RES_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_q      <= hold_q;
      out_last_q <= flush_i;
    end
    if (keep && ready_o) begin
      hold_q <= rec_i;
    end
  end

  assign hold_valid_o = hold_vld_q;
  assign out_valid_o  = out_vld_q;
  assign out_rec_o    = out_q;
  assign out_last_o   = out_last_q;

endmodule

/* design/lz_bitstream_decompressor_core.sv */
// Top level of the LZ bitstream decompressor: sequencer, history RAM, configuration.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  in       | in_valid_i / in_stall_o  | packed_byte_i, final_input_i
//  out      | out_valid_o / out_stall_i| out_byte_o, byte_present_o, run_end_o,
//           |                          | job_done_o, produced_total_o
//  cfg      | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// Without copies or stalls a transaction is accepted, decodes eight bits, then closes out.
// One bit is decoded per cycle unless a copy or emitter stall holds it; a literal is
// written in the cycle its last bit lands. A copy byte is a history RAM read, then a write.
// A final byte feeds zero fill bits until the parser idles, then the done result is sent.
// Reset clears the job state at once; the history RAM is not cleared.
// Output stalls hold the sequencer only when a result must move and both stages are full.
module lz_bitstream_decompressor_core import lzbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       packed_byte_i,
  input  logic             final_input_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             byte_present_o,
  output logic             run_end_o,
  output logic             job_done_o,
  output logic [CNT_W-1:0] produced_total_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [23:0]      cfg_wdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BIT  = 2'd1;
  localparam logic [1:0] ST_CRD  = 2'd2;
  localparam logic [1:0] ST_CWR  = 2'd3;

  localparam logic [1:0] REG_LOB   = 2'd0;
  localparam logic [1:0] REG_CAP   = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  logic [3:0]        lob_q;
  logic [2:0]        cap_q;
  logic [CNT_W-1:0]  limit_q;

  logic [1:0]        st_q, st_d;
  logic [7:0]        byte_q, byte_d;
  logic              fin_q, fin_d;
  logic [2:0]        bidx_q, bidx_d;
  logic              bdone_q, bdone_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  clen_q, clen_d;
  logic [DIST_W-1:0] cdist_q, cdist_d;

  logic              at_limit;
  logic              cur_bit;
  logic              work;
  logic              p_adv, p_clr, p_idle;
  cmd_t              cmd;

  logic              em_push, em_flush, em_ready, em_hold_vld;
  rec_t              em_rec;
  rec_t              out_rec;
  logic              out_last;

  logic              wr_en, rd_en;
  logic [7:0]        wr_data, rd_data, cbyte;
  logic [CNT_W-1:0]  from;

  assign at_limit = (cnt_q >= limit_q);
  assign cur_bit  = bdone_q ? 1'b0 : byte_q[bidx_q];
  assign work     = !bdone_q || (fin_q && !p_idle);
  assign from     = (CNT_W'(cdist_q) <= cnt_q) ? (cnt_q - CNT_W'(cdist_q)) : '0;
  assign cbyte    = (cnt_q == '0) ? 8'd0 : rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lob_q   <= 4'd8;
      cap_q   <= 3'd4;
      limit_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOB:   lob_q   <= cfg_wdata_i[3:0];
        REG_CAP:   cap_q   <= cfg_wdata_i[2:0];
        REG_LIMIT: limit_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  lzbd_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (p_adv),
    .clr_i      (p_clr),
    .bit_i      (cur_bit),
    .at_limit_i (at_limit),
    .lob_i      (lob_q),
    .cap_i      (cap_q),
    .cmd_o      (cmd),
    .idle_o     (p_idle)
  );

  lzbd_ram #(
    .DEPTH (HIST_DEPTH),
    .WIDTH (8)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[HIST_AW-1:0]),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (from[HIST_AW-1:0]),
    .rdata_o (rd_data)
  );

  lzbd_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (em_push),
    .rec_i        (em_rec),
    .flush_i      (em_flush),
    .ready_o      (em_ready),
    .hold_valid_o (em_hold_vld),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_rec_o    (out_rec),
    .out_last_o   (out_last)
  );

  always_comb begin
    st_d     = st_q;
    byte_d   = byte_q;
    fin_d    = fin_q;
    bidx_d   = bidx_q;
    bdone_d  = bdone_q;
    cnt_d    = cnt_q;
    clen_d   = clen_q;
    cdist_d  = cdist_q;
    p_adv    = 1'b0;
    p_clr    = 1'b0;
    em_push  = 1'b0;
    em_flush = 1'b0;
    em_rec   = '{data: cmd.lit, present: 1'b1, done: 1'b0, total: cnt_q + CNT_W'(1)};
    wr_en    = 1'b0;
    wr_data  = cmd.lit;
    rd_en    = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          byte_d  = packed_byte_i;
          fin_d   = final_input_i;
          bidx_d  = 3'd7;
          bdone_d = 1'b0;
          st_d    = ST_BIT;
        end
      end
      ST_BIT: begin
        if (work) begin
          case (cmd.kind)
            CMD_LIT: begin
              em_push = 1'b1;
              if (em_ready) begin
                p_adv = 1'b1;
                wr_en = 1'b1;
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            CMD_COPY: begin
              p_adv   = 1'b1;
              clen_d  = cmd.len;
              cdist_d = cmd.span;
              st_d    = ST_CRD;
            end
            default: begin
              p_adv = 1'b1;
            end
          endcase
          if (p_adv && !bdone_q) begin
            if (bidx_q == 3'd0) begin
              bdone_d = 1'b1;
            end else begin
              bidx_d = bidx_q - 3'd1;
            end
          end
        end else if (fin_q) begin
          em_push = 1'b1;
          em_rec  = '{data: 8'd0, present: 1'b0, done: 1'b1, total: cnt_q};
          if (em_ready) begin
            fin_d = 1'b0;
            cnt_d = '0;
            p_clr = 1'b1;
          end
        end else begin
          em_flush = 1'b1;
          if (em_ready) begin
            st_d = ST_IDLE;
          end
        end
      end
      ST_CRD: begin
        if (clen_q == '0 || at_limit) begin
          st_d = ST_BIT;
        end else begin
          rd_en = 1'b1;
          st_d  = ST_CWR;
        end
      end
      ST_CWR: begin
        em_push = 1'b1;
        em_rec  = '{data: cbyte, present: 1'b1, done: 1'b0, total: cnt_q + CNT_W'(1)};
        wr_data = cbyte;
        if (em_ready) begin
          wr_en  = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
          clen_d = clen_q - LEN_W'(1);
          st_d   = ST_CRD;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      fin_q   <= 1'b0;
      bidx_q  <= '0;
      bdone_q <= 1'b0;
      cnt_q   <= '0;
      clen_q  <= '0;
    end else begin
      st_q    <= st_d;
      fin_q   <= fin_d;
      bidx_q  <= bidx_d;
      bdone_q <= bdone_d;
      cnt_q   <= cnt_d;
      clen_q  <= clen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    cdist_q <= cdist_d;
  end

  assign in_stall_o       = (st_q != ST_IDLE);
  assign out_byte_o       = out_rec.data;
  assign byte_present_o   = out_rec.present;
  assign job_done_o       = out_rec.done;
  assign produced_total_o = out_rec.total;
  assign run_end_o        = out_last;

  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> !wr_en)
    else $error("history read and write in the same cycle");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && job_done_o) |-> (run_end_o && !byte_present_o))
    else $error("done result not tagged as last");

  a_idle_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> !em_hold_vld)
    else $error("held result left behind at end of transaction");

  a_copy_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CWR) |-> (clen_q != '0))
    else $error("copy byte written with no length left");

endmodule
